FILE: hw/rtl/lkvc_pkg.sv
// shared types and constants for the lru key-value cache
package lkvc_pkg;

   localparam int DATA_W     = 32;
   localparam int CAP_W      = 5;
   localparam int APB_ADDR_W = 3;
   localparam int APB_DATA_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } state_type;

endpackage

FILE: hw/rtl/lru_key_value_cache.sv
// lru key-value cache: parallel key match, value memory, recency ranks
// a get result is registered at the end of its lookup cycle and strobed on rsp_valid
// no new request is taken during a lookup; busy is high the cycle after a request is taken
// the lookup cycle matches all keys and reads the value memory; ranks update at its end
// reset is synchronous: clears valid marks, ranks, occupancy, capacity to 16, no clear pass
// results are shown for one cycle only; the receiver cannot stall them
module lru_key_value_cache
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_kind,
   input  logic signed [DATA_W-1:0] req_lookup_key,
   input  logic signed [DATA_W-1:0] req_store_value,
   output logic                    rsp_valid,
   output logic                    rsp_hit,
   output logic signed [DATA_W-1:0] rsp_read_value,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [APB_ADDR_W-1:0]   paddr,
   input  logic [APB_DATA_W-1:0]   pwdata,
   output logic [APB_DATA_W-1:0]   prdata,
   output logic                    pready
);

   localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = SLOT_W;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int EFF_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   state_type                 state_ff, state_in;
   logic                      kind_ff;
   logic [DATA_W-1:0]         key_req_ff, value_req_ff;
   logic [CAP_W-1:0]          cap_ff, cap_in;
   logic [ENTRIES-1:0]        valid_ff, valid_in;
   logic [RANK_W-1:0]         rank_ff [ENTRIES];
   logic [RANK_W-1:0]         rank_in [ENTRIES];
   logic [DATA_W-1:0]         key_ff  [ENTRIES];
   logic [OCC_W-1:0]          occ_ff, occ_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      hit_ff, hit_in;
   logic [DATA_W-1:0]         value_mem [ENTRIES];
   logic [DATA_W-1:0]         value_rd_ff;

   logic                      accept;
   logic                      cfg_write;
   logic                      in_lookup;
   logic [ENTRIES-1:0]        hit_vec;
   logic [ENTRIES-1:0]        victim_vec;
   logic [ENTRIES-1:0]        valid_left;
   logic                      any_hit;
   logic [SLOT_W-1:0]         hit_slot;
   logic [SLOT_W-1:0]         free_slot;
   logic [RANK_W-1:0]         hit_rank;
   logic [EFF_W-1:0]          eff_cap;
   logic                      do_evict;
   logic                      mem_we;
   logic [SLOT_W-1:0]         mem_waddr;
   logic                      key_we;

   assign accept    = start && !busy;
   assign busy      = (state_ff == ST_LOOKUP);
   assign in_lookup = (state_ff == ST_LOOKUP);
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(cap_ff) : '0;

   always_comb begin
      cap_in = cap_ff;
      if (cfg_write && paddr[2] == REG_CAPACITY) begin
         cap_in = pwdata[CAP_W-1:0];
      end
   end

   always_comb begin
      eff_cap = EFF_W'(cap_ff);
      if (cap_ff == '0) begin
         eff_cap = EFF_W'(1);
      end else if (EFF_W'(cap_ff) > EFF_W'(ENTRIES)) begin
         eff_cap = EFF_W'(ENTRIES);
      end
      do_evict = (EFF_W'(occ_ff) >= eff_cap);
   end

   // parallel key match and rank selection
   always_comb begin
      hit_slot = '0;
      hit_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i]    = valid_ff[i] && (key_ff[i] == key_req_ff);
         victim_vec[i] = valid_ff[i] && (OCC_W'(rank_ff[i]) == occ_ff - OCC_W'(1));
         if (hit_vec[i]) begin
            hit_slot = hit_slot | SLOT_W'(i);
            hit_rank = hit_rank | rank_ff[i];
         end
      end
      any_hit    = |hit_vec;
      valid_left = valid_ff & ~(do_evict ? victim_vec : '0);
      free_slot  = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_left[i]) begin
            free_slot = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      occ_in       = occ_ff;
      rsp_valid_in = 1'b0;
      hit_in       = hit_ff;
      mem_we       = 1'b0;
      mem_waddr    = hit_slot;
      key_we       = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in     = ST_IDLE;
            rsp_valid_in = (kind_ff == KIND_GET);
            hit_in       = any_hit;
            if (any_hit) begin
               mem_we = (kind_ff == KIND_PUT);
               for (int i = 0; i < ENTRIES; i++) begin
                  if (hit_vec[i]) begin
                     rank_in[i] = '0;
                  end else if (valid_ff[i] && rank_ff[i] < hit_rank) begin
                     rank_in[i] = rank_ff[i] + RANK_W'(1);
                  end
               end
            end else if (kind_ff == KIND_PUT) begin
               mem_we    = 1'b1;
               mem_waddr = free_slot;
               key_we    = 1'b1;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (SLOT_W'(i) == free_slot) begin
                     rank_in[i] = '0;
                  end else if (valid_left[i]) begin
                     rank_in[i] = rank_ff[i] + RANK_W'(1);
                  end else begin
                     rank_in[i] = '0;
                  end
               end
               valid_in = valid_left;
               valid_in[free_slot] = 1'b1;
               occ_in = do_evict ? occ_ff : occ_ff + OCC_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         valid_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      if (accept) begin
         kind_ff      <= req_kind;
         key_req_ff   <= req_lookup_key;
         value_req_ff <= req_store_value;
      end
      if (key_we) begin
         key_ff[free_slot] <= key_req_ff;
      end
   end

   // value memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         value_mem[mem_waddr] <= value_req_ff;
      end
      value_rd_ff <= value_mem[hit_slot];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = hit_ff;
   assign rsp_read_value = hit_ff ? value_rd_ff : '1;

`ifndef ASSERT_OFF
   a_rsp_after_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_LOOKUP))
      else $error("result strobe without a lookup cycle");

   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      OCC_W'($countones(valid_ff)) == occ_ff)
      else $error("occupancy differs from valid count");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      in_lookup |-> $onehot0(hit_vec))
      else $error("key present in more than one entry");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      EFF_W'(occ_ff) <= EFF_W'(ENTRIES))
      else $error("occupancy above entry count");
`endif

endmodule

FILE: tb/testbench.sv
// testbench for the lru key-value cache: directed table, then random phases against a predictor
`timescale 1ns / 100ps

module testbench;
   import lkvc_pkg::*;

   localparam int ENTRIES     = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REG_UNUSED  = 1;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 200;

   typedef enum logic [1:0] {
      ROW_GET,
      ROW_PUT,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] value;
   } lookup_result_type;

   typedef struct {
      row_kind_type      what;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
      bit                typed;
      logic              exp_hit;
      logic [DATA_W-1:0] exp_value;
   } stimulus_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_kind = KIND_GET;
   logic [DATA_W-1:0]     req_lookup_key = '0;
   logic [DATA_W-1:0]     req_store_value = '0;
   logic                  rsp_valid;
   logic                  rsp_hit;
   logic [DATA_W-1:0]     rsp_read_value;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [APB_ADDR_W-1:0] paddr = '0;
   logic [APB_DATA_W-1:0] pwdata = '0;
   logic [APB_DATA_W-1:0] prdata;
   logic                  pready;

   lru_key_value_cache #(.ENTRIES(ENTRIES)) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_lookup_key (req_lookup_key),
      .req_store_value(req_store_value),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // cache image kept by the testbench
   logic [DATA_W-1:0] line_key   [ENTRIES];
   logic [DATA_W-1:0] line_value [ENTRIES];
   bit                line_valid [ENTRIES];
   int unsigned       line_age   [ENTRIES];
   int unsigned       lines_held = 0;
   logic [CAP_W-1:0]  capacity_setting = CAP_RESET;

   lookup_result_type lookup_results_due [$];
   lookup_result_type oldest_due;
   int                mismatches = 0;
   int                cycle_count = 0;
   bit                idling_on = 1'b1;
   logic [DATA_W-1:0] key_pool [32];

   stimulus_row_type directed_rows [0:24] = '{
      '{ROW_GET, 32'h00000000, 32'h00000000, 1'b1, 1'b0, 32'hFFFFFFFF},
      '{ROW_GET, 32'h80000000, 32'h12345678, 1'b1, 1'b0, 32'hFFFFFFFF},
      '{ROW_PUT, 32'h7FFFFFFF, 32'h80000000, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h7FFFFFFF, 32'h00000000, 1'b1, 1'b1, 32'h80000000},
      '{ROW_PUT, 32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h80000000, 32'hFFFFFFFF, 1'b1, 1'b1, 32'h7FFFFFFF},
      '{ROW_PUT, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'hFFFFFFFF, 32'h00000000, 1'b1, 1'b1, 32'hFFFFFFFF},
      '{ROW_PUT, 32'h7FFFFFFF, 32'h00000000, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h7FFFFFFF, 32'h00000000, 1'b1, 1'b1, 32'h00000000},
      '{ROW_CSR, REG_UNUSED,   32'h00000003, 1'b0, 1'b0, 32'h0},
      '{ROW_PUT, 32'h00000001, 32'h00000011, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, REG_CAPACITY, 32'h00000002, 1'b0, 1'b0, 32'h0},
      '{ROW_PUT, 32'h00000002, 32'h00000022, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h80000000, 32'h00000000, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'hFFFFFFFF, 32'h00000000, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, REG_CAPACITY, 32'h00000000, 1'b0, 1'b0, 32'h0},
      '{ROW_PUT, 32'h00000003, 32'h00000033, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h00000003, 32'h00000000, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h00000002, 32'h00000000, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, REG_CAPACITY, 32'h0000001F, 1'b0, 1'b0, 32'h0},
      '{ROW_PUT, 32'h00000004, 32'h00000044, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h00000004, 32'h00000000, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h00000003, 32'h00000000, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, REG_CAPACITY, 32'h00000010, 1'b0, 1'b0, 32'h0}
   };

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      foreach (line_valid[i]) begin
         line_key[i]   = '0;
         line_value[i] = '0;
         line_valid[i] = 1'b0;
         line_age[i]   = 0;
      end
   end

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("mismatch: %s got %h expected %h at cycle %0d", what, got, want, cycle_count);
      mismatches++;
   endtask

   task automatic promote_line(input int slot);
      foreach (line_valid[i]) begin
         if (line_valid[i] && line_age[i] < line_age[slot]) begin
            line_age[i]++;
         end
      end
      line_age[slot] = 0;
   endtask

   task automatic predict_cache_step(input logic kind, input logic [DATA_W-1:0] key,
                                     input logic [DATA_W-1:0] value,
                                     output bit gives_result, output lookup_result_type outcome);
      int          found;
      int          victim;
      int          slot;
      int unsigned limit;
      found  = -1;
      victim = -1;
      slot   = -1;
      foreach (line_valid[i]) begin
         if (found < 0 && line_valid[i] && line_key[i] == key) begin
            found = i;
         end
      end
      gives_result  = (kind == KIND_GET);
      outcome.hit   = 1'b0;
      outcome.value = '1;
      if (kind == KIND_GET) begin
         if (found >= 0) begin
            outcome.hit   = 1'b1;
            outcome.value = line_value[found];
            promote_line(found);
         end
      end else if (found >= 0) begin
         line_value[found] = value;
         promote_line(found);
      end else begin
         limit = capacity_setting;
         if (limit < 1) limit = 1;
         if (limit > ENTRIES) limit = ENTRIES;
         if (lines_held >= limit) begin
            foreach (line_valid[i]) begin
               if (line_valid[i] && (victim < 0 || line_age[i] > line_age[victim])) begin
                  victim = i;
               end
            end
            if (victim >= 0) begin
               line_valid[victim] = 1'b0;
               line_age[victim]   = 0;
               lines_held--;
            end
         end
         foreach (line_valid[i]) begin
            if (slot < 0 && !line_valid[i]) begin
               slot = i;
            end
         end
         if (slot >= 0) begin
            foreach (line_valid[i]) begin
               if (line_valid[i]) line_age[i]++;
            end
            line_key[slot]   = key;
            line_value[slot] = value;
            line_valid[slot] = 1'b1;
            line_age[slot]   = 0;
            lines_held++;
         end
      end
   endtask

   task automatic send_request(input logic kind, input logic [DATA_W-1:0] key,
                               input logic [DATA_W-1:0] value, input bit typed,
                               input logic exp_hit, input logic [DATA_W-1:0] exp_value);
      bit                gives_result;
      lookup_result_type predicted;
      if (idling_on && $urandom_range(99) < 11) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start           <= 1'b1;
      req_kind        <= kind;
      req_lookup_key  <= key;
      req_store_value <= value;
      do @(posedge clock); while (busy);
      predict_cache_step(kind, key, value, gives_result, predicted);
      if (gives_result) begin
         if (typed) begin
            predicted.hit   = exp_hit;
            predicted.value = exp_value;
         end
         lookup_results_due.push_back(predicted);
      end
   endtask

   task automatic drain_requests();
      start <= 1'b0;
      while (lookup_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic csr_write(input int unsigned index, input logic [APB_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= APB_ADDR_W'(4 * index);
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (index == int'(REG_CAPACITY)) capacity_setting = data[CAP_W-1:0];
      @(posedge clock);
   endtask

   task automatic csr_check_capacity();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= APB_ADDR_W'(4 * int'(REG_CAPACITY));
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[CAP_W-1:0] !== capacity_setting) begin
         report_mismatch("capacity readback", prdata, DATA_W'(capacity_setting));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_W-1:0] setting);
      drain_requests();
      csr_write(int'(REG_CAPACITY), APB_DATA_W'(setting));
      csr_check_capacity();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (lookup_results_due.size() == 0) begin
            report_mismatch("result with no get pending", rsp_read_value, '0);
         end else begin
            oldest_due = lookup_results_due.pop_front();
            if (rsp_hit !== oldest_due.hit) begin
               report_mismatch("hit", DATA_W'(rsp_hit), DATA_W'(oldest_due.hit));
            end
            if (rsp_read_value !== oldest_due.value) begin
               report_mismatch("read value", rsp_read_value, oldest_due.value);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL lru_key_value_cache");
         $finish;
      end
   end

   initial begin
      logic [CAP_W-1:0]  phase_capacity [PHASES];
      int                pool_size;
      logic              kind;
      logic [DATA_W-1:0] key;
      phase_capacity = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd8, 5'd16, 5'd2, 5'd16};
      phase_capacity[5] = CAP_W'($urandom_range(0, 31));
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         case (directed_rows[r].what)
            ROW_CSR: begin
               drain_requests();
               csr_write(int'(directed_rows[r].key), directed_rows[r].value);
               csr_check_capacity();
            end
            default: begin
               send_request(directed_rows[r].what == ROW_PUT ? KIND_PUT : KIND_GET,
                            directed_rows[r].key, directed_rows[r].value,
                            directed_rows[r].typed, directed_rows[r].exp_hit,
                            directed_rows[r].exp_value);
            end
         endcase
      end

      for (int p = 0; p < PHASES; p++) begin
         set_capacity(phase_capacity[p]);
         idling_on = (p != 3);
         pool_size = $urandom_range(2, 24);
         foreach (key_pool[j]) key_pool[j] = $urandom;
         key_pool[0] = 32'h80000000;
         key_pool[1] = 32'h7FFFFFFF;
         if (pool_size > 4) begin
            key_pool[2] = 32'h00000000;
            key_pool[3] = 32'hFFFFFFFF;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == PHASE_ITEMS / 2) drain_requests();
            kind = ($urandom_range(1) == 1) ? KIND_PUT : KIND_GET;
            key  = ($urandom_range(99) < 92) ? key_pool[$urandom_range(pool_size - 1)] : $urandom;
            send_request(kind, key, $urandom, 1'b0, 1'b0, '0);
         end
      end

      start <= 1'b0;
      while (lookup_results_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS lru_key_value_cache");
      end else begin
         $display("FAIL lru_key_value_cache");
      end
      $finish;
   end

endmodule

FILE: lru_key_value_cache.f
hw/rtl/lkvc_pkg.sv
hw/rtl/lru_key_value_cache.sv
tb/testbench.sv
